>>> design/mcfe_pkg.sv
// Shared types and constants for the motor command frame encoder.
package mcfe_pkg;

	localparam int ID_W   = 8;
	localparam int POS_W  = 18;
	localparam int SPD_W  = 16;
	localparam int KP_W   = 11;
	localparam int KD_W   = 4;
	localparam int TQ_W   = 14;
	localparam int PPOS_W = 17;
	localparam int PSPD_W = 15;
	localparam int PTQ_W  = 13;
	localparam int CFG_W  = 17;
	localparam int ADDR_W = 2;

	// divider lane geometry: widest lane is position (18b offset * 16b scale)
	localparam int NUM_W  = 34;
	localparam int DEN_W  = 18;
	localparam int QUO_W  = 16;
	localparam int CODE_W = 12;
	localparam int LANES  = 3;

	localparam int KPC_W  = 9;
	localparam int KDC_W  = 3;
	localparam logic [KPC_W-1:0] KP_MAX = KPC_W'(500);
	localparam logic [KDC_W-1:0] KD_MAX = KDC_W'(5);

	// Kp code floor(k * 4095 / 500) = floor(k * 8.19): 8.19 * 2^16 rounded up,
	// exact for k up to 500. Kd code k * 4095 / 5 is exactly k * 819.
	localparam int KPM_W    = 20;
	localparam int KDM_W    = 10;
	localparam int KP_SHIFT = 16;
	localparam logic [KPM_W-1:0] KP_MUL = KPM_W'(536740);
	localparam logic [KDM_W-1:0] KD_MUL = KDM_W'(819);

	localparam logic [7:0] FILL_BYTE = 8'hFF;
	localparam logic [7:0] ON_BYTE   = 8'hFC;
	localparam logic [7:0] OFF_BYTE  = 8'hFD;

	localparam logic [PPOS_W-1:0] PPOS_RST = PPOS_W'(51200);
	localparam logic [PSPD_W-1:0] PSPD_RST = PSPD_W'(12800);
	localparam logic [PTQ_W-1:0]  PTQ_RST  = PTQ_W'(6349);

	// lane order
	localparam int L_POS = 0;
	localparam int L_SPD = 1;
	localparam int L_TQ  = 2;

	typedef enum logic [2:0] {
		OP_FULL   = 3'd0,
		OP_SPEED  = 3'd1,
		OP_TORQUE = 3'd2,
		OP_ON     = 3'd3,
		OP_OFF    = 3'd4
	} op_t;

	typedef enum logic [ADDR_W-1:0] {
		REG_PEAK_POS = 2'd0,
		REG_PEAK_SPD = 2'd1,
		REG_PEAK_TQ  = 2'd2
	} reg_idx_t;

	// per-item control and gain codes that ride alongside the divider lanes
	typedef struct packed {
		logic              fill;
		logic              off;
		logic [ID_W-1:0]   id;
		logic [CODE_W-1:0] kpc;
		logic [CODE_W-1:0] kdc;
	} frame_ctl_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage

>>> design/mcfe_prep.sv
// Front stages: mode select, clamping, offset and numerator build, gain codes.
module mcfe_prep import mcfe_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [2:0]               opcode,
	input  logic [ID_W-1:0]          dest_id,
	input  logic signed [POS_W-1:0]  target_position,
	input  logic signed [SPD_W-1:0]  target_speed,
	input  logic signed [KP_W-1:0]   stiffness_gain,
	input  logic signed [KD_W-1:0]   damping_gain,
	input  logic signed [TQ_W-1:0]   torque_feedforward,
	input  logic [PPOS_W-1:0]        pos_range,
	input  logic [PSPD_W-1:0]        spd_range,
	input  logic [PTQ_W-1:0]         tq_range,
	output logic                     valid_s2,
	output frame_ctl_t               ctl_s2,
	output div_req_t                 req_s2 [LANES]
);

	// clamp v to [-p, p] and return v + p (0..2p)
	function automatic logic [DEN_W-1:0] clamp_ofs(logic signed [DEN_W:0] v,
			logic [PPOS_W-1:0] p);
		logic signed [DEN_W:0] ps;
		logic signed [DEN_W:0] c;
		ps = $signed({2'b00, p});
		if (v > ps)
			c = ps;
		else if (v < -ps)
			c = -ps;
		else
			c = v;
		clamp_ofs = DEN_W'(c + ps);
	endfunction

	logic                     valid_s1;
	logic                     fill_s1, off_s1;
	logic [ID_W-1:0]          id_s1;
	logic [DEN_W-1:0]         ofs_pos_s1, ofs_spd_s1, ofs_tq_s1;
	logic [KPC_W-1:0]         kp_s1;
	logic [KDC_W-1:0]         kd_s1;
	logic                     zpos_s1, zspd_s1, ztq_s1;
	logic [DEN_W-1:0]         dpos_s1, dspd_s1, dtq_s1;

	logic                     op_ok;
	logic                     use_pos, use_spd, use_kt;
	logic signed [DEN_W:0]    pos_x, spd_x, tq_x;
	logic [KPC_W-1:0]         kp_c;
	logic [KDC_W-1:0]         kd_c;

	// stage 1: select per mode and saturate
	always_comb begin
		op_ok   = (opcode <= OP_OFF);
		use_pos = (opcode == OP_FULL);
		use_spd = (opcode == OP_FULL) || (opcode == OP_SPEED);
		use_kt  = (opcode != OP_SPEED);
		pos_x   = use_pos ? (DEN_W+1)'(target_position) : '0;
		spd_x   = use_spd ? (DEN_W+1)'(target_speed) : '0;
		tq_x    = use_kt ? (DEN_W+1)'(torque_feedforward) : '0;
		if (!use_kt || stiffness_gain < 0)
			kp_c = '0;
		else if (stiffness_gain > $signed({2'b00, KP_MAX}))
			kp_c = KP_MAX;
		else
			kp_c = KPC_W'(stiffness_gain);
		if (damping_gain < 0)
			kd_c = '0;
		else if (damping_gain > $signed({1'b0, KD_MAX}))
			kd_c = KD_MAX;
		else
			kd_c = KDC_W'(damping_gain);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid && op_ok;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fill_s1     <= (opcode == OP_ON) || (opcode == OP_OFF);
			off_s1      <= (opcode == OP_OFF);
			id_s1       <= dest_id;
			ofs_pos_s1  <= clamp_ofs(pos_x, pos_range);
			ofs_spd_s1  <= clamp_ofs(spd_x, PPOS_W'(spd_range));
			ofs_tq_s1   <= clamp_ofs(tq_x, PPOS_W'(tq_range));
			kp_s1       <= kp_c;
			kd_s1       <= kd_c;
			zpos_s1     <= (pos_range == '0);
			zspd_s1     <= (spd_range == '0);
			ztq_s1      <= (tq_range == '0);
			dpos_s1     <= {pos_range, 1'b0};
			dspd_s1     <= DEN_W'({spd_range, 1'b0});
			dtq_s1      <= DEN_W'({tq_range, 1'b0});
		end
	end

	// stage 2: numerator = offset * (2^b - 1) by shift and subtract
	logic [NUM_W-1:0] np, ns, nt;
	always_comb begin
		np  = (NUM_W'(ofs_pos_s1) << 16) - NUM_W'(ofs_pos_s1);
		ns  = (NUM_W'(ofs_spd_s1) << CODE_W) - NUM_W'(ofs_spd_s1);
		nt  = (NUM_W'(ofs_tq_s1) << CODE_W) - NUM_W'(ofs_tq_s1);
	end

	// stage 2: gain codes by constant multiply
	logic [KPC_W+KPM_W-1:0] kp_prod;
	logic [KDC_W+KDM_W-1:0] kd_prod;
	logic [CODE_W-1:0]      kpc_c, kdc_c;
	always_comb begin
		kp_prod = (KPC_W+KPM_W)'(kp_s1) * (KPC_W+KPM_W)'(KP_MUL);
		kpc_c   = kp_prod[KP_SHIFT +: CODE_W];
		kd_prod = (KDC_W+KDM_W)'(kd_s1) * (KDC_W+KDM_W)'(KD_MUL);
		kdc_c   = kd_prod[CODE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= {fill_s1, off_s1, id_s1, kpc_c, kdc_c};
			// zero peak gives midscale: numerator is the midscale code over one
			req_s2[L_POS].num <= zpos_s1 ? NUM_W'(16'h7FFF) : np;
			req_s2[L_POS].den <= zpos_s1 ? DEN_W'(1) : dpos_s1;
			req_s2[L_SPD].num <= zspd_s1 ? NUM_W'(12'h7FF) : ns;
			req_s2[L_SPD].den <= zspd_s1 ? DEN_W'(1) : dspd_s1;
			req_s2[L_TQ].num  <= ztq_s1 ? NUM_W'(12'h7FF) : nt;
			req_s2[L_TQ].den  <= ztq_s1 ? DEN_W'(1) : dtq_s1;
		end
	end

endmodule

>>> design/mcfe_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
module mcfe_div import mcfe_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  div_req_t         req,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];

	assign rem_s[0] = req.num;
	assign den_s[0] = req.den;
	assign quo_s[0] = '0;

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		localparam int BIT = QUO_W - 1 - j;
		logic [NUM_W-1:0] sh;
		logic             ge;
		always_comb begin
			sh = NUM_W'(den_s[j]) << BIT;
			ge = (rem_s[j] >= sh);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? (rem_s[j] - sh) : rem_s[j];
				den_s[j+1] <= den_s[j];
				quo_s[j+1] <= quo_s[j] | (ge ? (QUO_W'(1) << BIT) : '0);
			end
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

>>> design/motor_command_frame_encoder_top.sv
// Motor command frame encoder: top level with config registers and output stage.
// Takes one command item per clock and returns one frame item (CAN id plus eight
// payload bytes) through two front stages (mode select and clamp, then
// numerator build and gain codes), sixteen restoring-divider stages and one output
// register. Unused opcodes (5..7) are dropped and give no frame. The whole pipe
// advances together whenever the output register is empty or taken, so tready is
// low only while a finished frame waits at the output.
module motor_command_frame_encoder_top import mcfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// config write port
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// command stream
	input  logic              s_tvalid,
	output logic              s_tready,
	// tdata: dest_id[7:0], target_position[25:8], target_speed[41:26],
	//        stiffness_gain[52:42], damping_gain[56:53], torque_feedforward[70:57]
	input  logic [71:0]       s_tdata,
	// tuser: opcode[2:0]
	input  logic [2:0]        s_tuser,
	// frame stream
	output logic              m_tvalid,
	input  logic              m_tready,
	// tdata: can_id[7:0], payload_0[15:8] .. payload_7[71:64]
	output logic [71:0]       m_tdata
);

	logic [PPOS_W-1:0] peak_pos_q;
	logic [PSPD_W-1:0] peak_spd_q;
	logic [PTQ_W-1:0]  peak_tq_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_pos_q <= PPOS_RST;
			peak_spd_q <= PSPD_RST;
			peak_tq_q  <= PTQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PEAK_POS: peak_pos_q <= cfg_wdata[PPOS_W-1:0];
				REG_PEAK_SPD: peak_spd_q <= cfg_wdata[PSPD_W-1:0];
				REG_PEAK_TQ:  peak_tq_q  <= cfg_wdata[PTQ_W-1:0];
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	logic en;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	logic       valid_s2;
	frame_ctl_t ctl_s2;
	div_req_t   req_s2 [LANES];

	mcfe_prep u_prep (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (en),
		.in_valid           (s_tvalid),
		.opcode             (s_tuser),
		.dest_id            (s_tdata[7:0]),
		.target_position    (s_tdata[25:8]),
		.target_speed       (s_tdata[41:26]),
		.stiffness_gain     (s_tdata[52:42]),
		.damping_gain       (s_tdata[56:53]),
		.torque_feedforward (s_tdata[70:57]),
		.pos_range          (peak_pos_q),
		.spd_range          (peak_spd_q),
		.tq_range           (peak_tq_q),
		.valid_s2           (valid_s2),
		.ctl_s2             (ctl_s2),
		.req_s2             (req_s2)
	);

	logic [QUO_W-1:0] quo [LANES];
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		mcfe_div u_div (
			.clk (clk),
			.en  (en),
			.req (req_s2[l]),
			.quo (quo[l])
		);
	end

	// control and valid delay line matching the divider depth
	logic       vld_d [QUO_W+1];
	frame_ctl_t ctl_d [QUO_W+1];
	assign vld_d[0] = valid_s2;
	assign ctl_d[0] = ctl_s2;

	for (genvar j = 0; j < QUO_W; j++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_d[j+1] <= 1'b0;
			else if (en)
				vld_d[j+1] <= vld_d[j];
		end
		always_ff @(posedge clk) begin
			if (en)
				ctl_d[j+1] <= ctl_d[j];
		end
	end

	// frame packing, big-endian codes
	logic [QUO_W-1:0]  pc;
	logic [CODE_W-1:0] sc, kpc, kdc, tc;
	logic [71:0]       frame;
	frame_ctl_t        fc;
	always_comb begin
		fc  = ctl_d[QUO_W];
		pc  = quo[L_POS];
		sc  = quo[L_SPD][CODE_W-1:0];
		kpc = fc.kpc;
		kdc = fc.kdc;
		tc  = quo[L_TQ][CODE_W-1:0];
		if (fc.fill)
			frame = {(fc.off ? OFF_BYTE : ON_BYTE), {7{FILL_BYTE}}, fc.id};
		else
			frame = {tc[7:0], kdc[3:0], tc[11:8], kdc[11:4], kpc[7:0],
				sc[3:0], kpc[11:8], sc[11:4], pc[7:0], pc[15:8], fc.id};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= vld_d[QUO_W];
	end

	logic [71:0] out_data_q;
	always_ff @(posedge clk) begin
		if (en)
			out_data_q <= frame;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> design/mcfe_checker.sv
// Port-level checks for the motor command frame encoder, bound to the top level.
module mcfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// input side opens exactly when the output slot is free or drains
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output slot state");

	// a frame leaves only through a handshake
	a_drop_only_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("frame dropped without handshake");

	// stalled frame holds its contents
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled frame changed");

endmodule

bind motor_command_frame_encoder_top mcfe_checker u_mcfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
